// ===== hw/rtl/fdms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdms_pkg;

  // Queue depth default
  localparam int QUEUE_DEPTH_DEF = 16;

  // Configuration port widths
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DOOR_DELAY_MS   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_TARGET = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DOOR_DUTY       = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDER_DUTY     = 8'd3;

  // Register reset values
  localparam logic [15:0] DOOR_DELAY_RST   = 16'd1000;
  localparam logic [7:0]  ROT_TARGET_RST   = 8'd4;
  localparam logic [7:0]  DOOR_DUTY_RST    = 8'd128;
  localparam logic [7:0]  FEEDER_DUTY_RST  = 8'd128;

  // Door drive codes
  localparam logic [1:0] DOOR_STOP  = 2'd0;
  localparam logic [1:0] DOOR_OPEN  = 2'd1;
  localparam logic [1:0] DOOR_CLOSE = 2'd2;

  // Queued command codes
  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  // One millisecond tick
  typedef struct packed {
    logic door_sensor;
    logic feeder_sensor;
    logic toggle;
  } tick_t;

  // One result item
  typedef struct packed {
    logic [1:0] door_drive;
    logic       feeder_drive;
    logic [7:0] door_pwm;
    logic [7:0] feeder_pwm;
    logic [2:0] mode;
    logic       toggle_dropped;
  } result_t;

  // Configuration write
  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fdms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick input channel
interface fdms_tick_if;
  import fdms_pkg::*;
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result output channel
interface fdms_result_if;
  import fdms_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface fdms_cfg_if;
  import fdms_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/feeder_door_motor_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                  Transfer
// tick      in   door_sensor, feeder_sensor, toggle       valid & ready
// result    out  drives, pwm duties, mode, toggle_dropped valid & ready
// cfg       in   index (8b), data (16b)                   valid & ready, ready always 1
//
// One tick per clock while no result stalls; the result sits in the output register
// the cycle after the tick transfer. The state update is a single register stage.
// Synchronous active-high reset returns to init mode with registers at defaults.
// A stalled result holds tick.ready low until it is taken, or taken the same cycle.
// Toggles always enqueue open, feed, close in that order, so the queue is held
// as a fill count plus a three-phase pointer to the command at its head.
module feeder_door_motor_sequencer
  import fdms_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst,
  fdms_tick_if.sink      tick,
  fdms_result_if.source  result,
  fdms_cfg_if.sink       cfg
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    M_INIT  = 3'd0,
    M_IDLE  = 3'd1,
    M_OPEN  = 3'd2,
    M_CLOSE = 3'd3,
    M_FEED  = 3'd4
  } mode_t;

  // Configuration registers
  logic [15:0] door_delay_ms;
  logic [7:0]  rotation_target;
  logic [7:0]  door_duty;
  logic [7:0]  feeder_duty;

  // Sequencer state
  logic [2:0]    mode_reg, mode_reg_next;
  logic [15:0]   elapsed_ms, elapsed_ms_next;
  logic          last_feeder_level, last_feeder_level_next;
  logic [7:0]    rotation_count, rotation_count_next;
  logic [CW-1:0] fifo_count, fifo_count_next;
  cmd_t          head_cmd, head_cmd_next;
  logic          door_pwm_started, door_pwm_started_next;
  logic          feeder_pwm_started, feeder_pwm_started_next;
  logic          dropped;

  logic [CW:0]   count_plus3;
  logic [CW-1:0] count_pushed;
  logic [15:0]   elapsed_inc;
  logic [7:0]    rot_inc;

  logic   tick_xfer;
  logic   out_valid;
  result_t out_data;

  assign tick.ready   = !out_valid || result.ready;
  assign tick_xfer    = tick.valid && tick.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      door_delay_ms   <= DOOR_DELAY_RST;
      rotation_target <= ROT_TARGET_RST;
      door_duty       <= DOOR_DUTY_RST;
      feeder_duty     <= FEEDER_DUTY_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_DOOR_DELAY_MS:   door_delay_ms   <= cfg.data.data;
        REG_ROTATION_TARGET: rotation_target <= cfg.data.data[7:0];
        REG_DOOR_DUTY:       door_duty       <= cfg.data.data[7:0];
        REG_FEEDER_DUTY:     feeder_duty     <= cfg.data.data[7:0];
        default: ;
      endcase
    end
  end

  // Step logic for one tick
  always_comb begin
    mode_reg_next           = mode_reg;
    elapsed_ms_next         = elapsed_ms;
    last_feeder_level_next  = last_feeder_level;
    rotation_count_next     = rotation_count;
    head_cmd_next           = head_cmd;
    door_pwm_started_next   = door_pwm_started;
    feeder_pwm_started_next = feeder_pwm_started;
    dropped                 = 1'b0;

    // queue the triple ahead of the step when there is room
    count_plus3  = {1'b0, fifo_count} + (CW + 1)'(3);
    count_pushed = fifo_count;
    if (tick.data.toggle) begin
      if (count_plus3 <= DEPTH_W) begin
        count_pushed = count_plus3[CW-1:0];
      end else begin
        dropped = 1'b1;
      end
    end
    fifo_count_next = count_pushed;

    elapsed_inc = (elapsed_ms == 16'hFFFF) ? elapsed_ms : elapsed_ms + 16'd1;
    rot_inc     = (rotation_count == 8'hFF) ? rotation_count : rotation_count + 8'd1;

    case (mode_reg)
      M_IDLE: begin
        if (count_pushed != '0) begin
          fifo_count_next = count_pushed - CW'(1);
          case (head_cmd)
            CMD_OPEN, CMD_CLOSE: begin
              elapsed_ms_next       = '0;
              door_pwm_started_next = 1'b1;
              mode_reg_next         = (head_cmd == CMD_OPEN) ? M_OPEN : M_CLOSE;
            end
            CMD_FEED: begin
              last_feeder_level_next  = tick.data.feeder_sensor;
              rotation_count_next     = '0;
              feeder_pwm_started_next = 1'b1;
              mode_reg_next           = M_FEED;
            end
            default: mode_reg_next = M_IDLE;
          endcase
          case (head_cmd)
            CMD_OPEN: head_cmd_next = CMD_FEED;
            CMD_FEED: head_cmd_next = CMD_CLOSE;
            default:  head_cmd_next = CMD_OPEN;
          endcase
        end
      end
      M_OPEN, M_CLOSE: begin
        elapsed_ms_next = elapsed_inc;
        if (elapsed_inc > door_delay_ms && tick.data.door_sensor) begin
          mode_reg_next = M_IDLE;
        end
      end
      M_FEED: begin
        if (tick.data.feeder_sensor != last_feeder_level) begin
          rotation_count_next    = rot_inc;
          last_feeder_level_next = tick.data.feeder_sensor;
        end
        if (rotation_count_next >= rotation_target) begin
          mode_reg_next = M_IDLE;
        end
      end
      default: mode_reg_next = M_IDLE;
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg           <= M_INIT;
      elapsed_ms         <= '0;
      last_feeder_level  <= 1'b0;
      rotation_count     <= '0;
      fifo_count         <= '0;
      head_cmd           <= CMD_OPEN;
      door_pwm_started   <= 1'b0;
      feeder_pwm_started <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      // result stays valid until taken, reloads on a tick transfer
      out_valid <= tick_xfer || (out_valid && !result.ready);
      if (tick_xfer) begin
        mode_reg           <= mode_reg_next;
        elapsed_ms         <= elapsed_ms_next;
        last_feeder_level  <= last_feeder_level_next;
        rotation_count     <= rotation_count_next;
        fifo_count         <= fifo_count_next;
        head_cmd           <= head_cmd_next;
        door_pwm_started   <= door_pwm_started_next;
        feeder_pwm_started <= feeder_pwm_started_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      case (mode_reg_next)
        M_OPEN:  out_data.door_drive <= DOOR_OPEN;
        M_CLOSE: out_data.door_drive <= DOOR_CLOSE;
        default: out_data.door_drive <= DOOR_STOP;
      endcase
      out_data.feeder_drive   <= (mode_reg_next == M_FEED);
      out_data.door_pwm       <= door_pwm_started_next ? door_duty : 8'd0;
      out_data.feeder_pwm     <= feeder_pwm_started_next ? feeder_duty : 8'd0;
      out_data.mode           <= mode_reg_next;
      out_data.toggle_dropped <= dropped;
    end
  end

endmodule

`default_nettype wire
